// File: rtl/b2da_pkg.sv
// shared types and constants for the binary to decimal ascii converter
`default_nettype none
package b2da_pkg;

   localparam int VALUE_W   = 32;
   localparam int NUM_DIGS  = 10;
   localparam int BCD_W     = 4 * NUM_DIGS;
   localparam int STEP_W    = $clog2(VALUE_W);
   localparam int CNT_W     = 4;
   localparam int CHAR_W    = 6;

   localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;
   localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(VALUE_W - 1);

   // controller to datapath
   typedef struct packed {
      logic load;
      logic shift;
      logic scan;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last;
   } status_type;

endpackage
`default_nettype wire

// File: rtl/b2da_ctrl.sv
// sequencing state machine for the converter
`default_nettype none
module b2da_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   output b2da_pkg::cmd_type        cmd,
   input  wire b2da_pkg::status_type status
);
   import b2da_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CONV = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      busy      = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.shift = 1'b1;
            step_in   = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (status.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/b2da_dpath.sv
// shift-and-add-3 bcd converter, digit counter and output registers
`default_nettype none
module b2da_dpath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire b2da_pkg::cmd_type                 cmd,
   output b2da_pkg::status_type                   status,
   input  wire logic [b2da_pkg::VALUE_W-1:0]      req_value,
   output logic                                   rsp_valid,
   output logic [b2da_pkg::CHAR_W-1:0]            rsp_digit_char,
   output logic [b2da_pkg::CNT_W-1:0]             rsp_digit_count,
   output logic                                   rsp_last_digit
);
   import b2da_pkg::*;

   logic [VALUE_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic [CNT_W-1:0]   rsp_cnt_ff, rsp_cnt_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [BCD_W-1:0]   adj;
   logic [CNT_W-1:0]   found;
   logic [3:0]         cur_dig;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < NUM_DIGS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   // highest nonzero digit gives the digit count, at least one
   always_comb begin
      found = CNT_W'(1);
      for (int i = 1; i < NUM_DIGS; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0) begin
            found = CNT_W'(i + 1);
         end
      end
   end

   always_comb begin
      cur_dig = 4'd0;
      for (int i = 0; i < NUM_DIGS; i++) begin
         if (pos_ff == CNT_W'(i)) begin
            cur_dig = bcd_ff[4*i +: 4];
         end
      end
   end

   assign status.last = (pos_ff == '0);

   always_comb begin
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      rsp_valid_in = 1'b0;
      rsp_char_in  = rsp_char_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.load) begin
         bin_in = req_value;
         bcd_in = '0;
      end
      if (cmd.shift) begin
         {bcd_in, bin_in} = {adj[BCD_W-2:0], bin_ff, 1'b0};
      end
      if (cmd.scan) begin
         cnt_in = found;
         pos_in = found - 1'b1;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = ASCII_ZERO + {{(CHAR_W-4){1'b0}}, cur_dig};
         rsp_cnt_in   = cnt_ff;
         rsp_last_in  = status.last;
         pos_in       = pos_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      cnt_ff      <= cnt_in;
      pos_ff      <= pos_in;
      rsp_char_ff <= rsp_char_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digit_char  = rsp_char_ff;
   assign rsp_digit_count = rsp_cnt_ff;
   assign rsp_last_digit  = rsp_last_ff;

endmodule
`default_nettype wire

// File: rtl/binary_to_decimal_ascii.sv
// Converts an unsigned 32-bit value to decimal ASCII text, most significant digit first,
// leading zeros suppressed (zero gives a single '0'). A transaction is taken when start
// is high and busy is low. Conversion runs a serial shift-and-add-3 loop over all 32 bits,
// a scan step then finds the digit count, then one digit per cycle comes out on rsp_valid.
// Each digit is shown for exactly one cycle and the receiver cannot stall it; busy drops
// while the final digit is still on the result ports, so the next transaction may start
// at once.
`default_nettype none
module binary_to_decimal_ascii (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [b2da_pkg::VALUE_W-1:0] req_value,
   output logic                              rsp_valid,
   output logic [b2da_pkg::CHAR_W-1:0]       rsp_digit_char,
   output logic [b2da_pkg::CNT_W-1:0]        rsp_digit_count,
   output logic                              rsp_last_digit
);
   import b2da_pkg::*;

   cmd_type    cmd;
   status_type status;

   b2da_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   b2da_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_digit_char  (rsp_digit_char),
      .rsp_digit_count (rsp_digit_count),
      .rsp_last_digit  (rsp_last_digit)
   );

endmodule
`default_nettype wire

// File: rtl/b2da_chk.sv
// port-level checks for the converter, bound to the top level
`default_nettype none
module b2da_chk (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         start,
   input wire logic                         busy,
   input wire logic                         rsp_valid,
   input wire logic [b2da_pkg::CHAR_W-1:0]  rsp_digit_char,
   input wire logic [b2da_pkg::CNT_W-1:0]   rsp_digit_count,
   input wire logic                         rsp_last_digit
);
   import b2da_pkg::*;

   // block comes out of reset idle
   a_reset_idle: assert property (@(posedge clock) reset |=> !busy)
      else $error("busy right after reset");

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("transaction taken but block not busy");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_digit_char >= ASCII_ZERO && rsp_digit_char <= ASCII_ZERO + 6'd9
                    && rsp_digit_count >= 4'd1 && rsp_digit_count <= 4'd10)
      else $error("digit or count out of range");

   // digits of one value come back to back with one count
   a_digit_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_digit |=> rsp_valid && $stable(rsp_digit_count))
      else $error("digit run broken");

endmodule

bind binary_to_decimal_ascii b2da_chk u_chk (.*);
`default_nettype wire

// File: bench/binary_to_decimal_ascii_tb.sv
// testbench for the binary to decimal ascii converter: directed table, then random values
`timescale 1ns / 1ps
module binary_to_decimal_ascii_tb;
   import b2da_pkg::*;

   localparam int NDIR       = 24;
   localparam int NRAND      = 450;
   localparam int TEXT_W     = 8 * NUM_DIGS;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 60;

   typedef struct packed {
      logic [CHAR_W-1:0] ascii;
      logic [CNT_W-1:0]  count;
      logic              last;
   } digit_type;

   // nonzero text means the expected digits are typed in, otherwise they are predicted
   localparam logic [VALUE_W-1:0] DIR_VALUE [NDIR] = '{
      32'd0, 32'd4294967295, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999,
      32'd1000, 32'd65535, 32'd65536, 32'd99999999, 32'd100000000, 32'd999999999,
      32'd1000000000, 32'd2147483647, 32'd2147483648, 32'd4294967294,
      32'hAAAA_AAAA, 32'h5555_5555, 32'd4000000000, 32'd12345, 32'd1234567890, 32'd7
   };
   localparam logic [TEXT_W-1:0] DIR_TEXT [NDIR] = '{
      TEXT_W'("0"), TEXT_W'("4294967295"), TEXT_W'("1"), TEXT_W'("9"), TEXT_W'("10"),
      '0, '0, '0, '0, '0, '0, '0, '0, '0,
      TEXT_W'("1000000000"), TEXT_W'("2147483647"), TEXT_W'("2147483648"),
      '0, '0, '0, '0, '0, TEXT_W'("1234567890"), '0
   };

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [VALUE_W-1:0] req_value;
   logic               rsp_valid;
   logic [CHAR_W-1:0]  rsp_digit_char;
   logic [CNT_W-1:0]   rsp_digit_count;
   logic               rsp_last_digit;

   digit_type pending_digits [$];
   int     fail_count = 0;
   int     cycle_count = 0;
   bit     idle_on = 1'b1;

   binary_to_decimal_ascii u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_digit_char  (rsp_digit_char),
      .rsp_digit_count (rsp_digit_count),
      .rsp_last_digit  (rsp_last_digit)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // queue the digits of one value, most significant first
   task automatic queue_digits(input logic [VALUE_W-1:0] v, input logic [TEXT_W-1:0] text);
      logic [CHAR_W-1:0]  codes [NUM_DIGS];
      logic [VALUE_W-1:0] rest;
      int                 n;
      digit_type          d;
      n = 0;
      if (text != '0) begin
         for (int i = 0; i < NUM_DIGS; i++)
            if (text[8*i +: 8] != 8'h00) n = i + 1;
         for (int k = 0; k < n; k++)
            codes[k] = text[8*(n-1-k) +: CHAR_W];
      end else begin
         rest = v;
         do begin
            codes[NUM_DIGS-1-n] = ASCII_ZERO + CHAR_W'(rest % 10);
            n++;
            rest = rest / 10;
         end while (rest != 0);
         for (int k = 0; k < n; k++)
            codes[k] = codes[NUM_DIGS-n+k];
      end
      for (int k = 0; k < n; k++) begin
         d.ascii = codes[k];
         d.count = CNT_W'(n);
         d.last  = (k == n - 1);
         pending_digits.push_back(d);
      end
   endtask

   // hold one transaction on the request ports until it is taken
   task automatic send_value(input logic [VALUE_W-1:0] v, input logic [TEXT_W-1:0] text);
      bit s;
      bit taken;
      taken = 1'b0;
      req_value <= v;
      while (!taken) begin
         s = !(idle_on && ($urandom_range(99) < 8));
         start <= s;
         @(posedge clock);
         if (s && !busy) taken = 1'b1;
      end
      queue_digits(v, text);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_digits.size() == 0) begin
            $error("digit with nothing expected: char %h count %0d last %b",
                   rsp_digit_char, rsp_digit_count, rsp_last_digit);
            fail_count++;
         end else begin
            digit_type e;
            e = pending_digits.pop_front();
            if (rsp_digit_char !== e.ascii) begin
               $error("digit_char: expected %h, got %h", e.ascii, rsp_digit_char);
               fail_count++;
            end
            if (rsp_digit_count !== e.count) begin
               $error("digit_count: expected %0d, got %0d", e.count, rsp_digit_count);
               fail_count++;
            end
            if (rsp_last_digit !== e.last) begin
               $error("last_digit: expected %b, got %b", e.last, rsp_last_digit);
               fail_count++;
            end
         end
      end
   end

   initial begin
      logic [63:0]        lo;
      logic [63:0]        hi;
      logic [VALUE_W-1:0] v;
      int                 len;
      reset     = 1'b1;
      start     = 1'b0;
      req_value = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NDIR; i++)
         send_value(DIR_VALUE[i], DIR_TEXT[i]);

      for (int i = 0; i < NRAND; i++) begin
         idle_on = !(i >= 150 && i < 250);
         if (i == 300) begin
            // let the block drain completely before going on
            start <= 1'b0;
            @(posedge clock);
            while (pending_digits.size() != 0) @(posedge clock);
         end
         case ($urandom_range(4))
            0: v = $urandom;
            1: begin
               // value with a chosen number of digits
               len = $urandom_range(NUM_DIGS, 1);
               lo = 64'd1;
               for (int k = 1; k < len; k++) lo = lo * 10;
               hi = lo * 10 - 1;
               if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
               v = VALUE_W'(lo) + $urandom_range(VALUE_W'(hi - lo));
            end
            2: begin
               // just around a power of ten
               len = $urandom_range(NUM_DIGS - 1, 1);
               lo = 64'd1;
               for (int k = 0; k < len; k++) lo = lo * 10;
               v = VALUE_W'(lo) + $urandom_range(4) - 2;
            end
            3: v = $urandom_range(1000);
            default: v = $urandom | 32'hF000_0000;
         endcase
         send_value(v, '0);
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending_digits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// File: files.f
rtl/b2da_pkg.sv
rtl/b2da_ctrl.sv
rtl/b2da_dpath.sv
rtl/binary_to_decimal_ascii.sv
rtl/b2da_chk.sv
bench/binary_to_decimal_ascii_tb.sv
